FILE: hdl/tls_pkg.sv
// shared types, constants and helper functions for the traffic light sequencer
package tls_pkg;

    // cycle phases
    typedef enum logic [3:0] {
        PH_START      = 4'd0,
        PH_NS_WALK    = 4'd1,
        PH_NS_GREEN   = 4'd2,
        PH_NS_YELLOW  = 4'd3,
        PH_EWT_GREEN  = 4'd4,
        PH_EWT_YELLOW = 4'd5,
        PH_EW_WALK    = 4'd6,
        PH_EW_GREEN   = 4'd7,
        PH_EW_YELLOW  = 4'd8,
        PH_NST_GREEN  = 4'd9,
        PH_NST_YELLOW = 4'd10
    } phase_t;

    // lamp colors
    typedef enum logic [1:0] {
        LAMP_OFF    = 2'd0,
        LAMP_RED    = 2'd1,
        LAMP_GREEN  = 2'd2,
        LAMP_YELLOW = 2'd3
    } lamp_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_DAY_THRESHOLD   = 3'd0,
        CFG_DAY_NS_GREEN    = 3'd1,
        CFG_DAY_EW_GREEN    = 3'd2,
        CFG_NIGHT_GREEN     = 3'd3,
        CFG_YELLOW          = 3'd4,
        CFG_TURN_GREEN      = 3'd5,
        CFG_NS_WALK         = 3'd6,
        CFG_EW_WALK         = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;

    // register reset values
    localparam logic [9:0] DAY_THRESHOLD_RST = 10'd512;
    localparam logic [3:0] DAY_NS_GREEN_RST  = 4'd9;
    localparam logic [3:0] DAY_EW_GREEN_RST  = 4'd7;
    localparam logic [3:0] NIGHT_GREEN_RST   = 4'd8;
    localparam logic [3:0] YELLOW_RST        = 4'd3;
    localparam logic [3:0] TURN_GREEN_RST    = 4'd6;
    localparam logic [3:0] NS_WALK_RST       = 4'd6;
    localparam logic [3:0] EW_WALK_RST       = 4'd9;

    localparam logic [3:0] MAX_WALK  = 4'd10;
    localparam logic [3:0] MAX_DIGIT = 4'd9;

    localparam logic [6:0] BLANK_PATTERN = 7'h7F;

    // active-low g..a patterns, digit 0 shown blank
    localparam logic [6:0] SEG_TABLE [10] = '{
        7'h7F, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
    };

    // configuration register file
    typedef struct packed {
        logic [9:0] day_threshold;
        logic [3:0] day_ns_green_time;
        logic [3:0] day_ew_green_time;
        logic [3:0] night_green_time;
        logic [3:0] yellow_time;
        logic [3:0] turn_green_time;
        logic [3:0] ns_walk_time;
        logic [3:0] ew_walk_time;
    } cfg_t;

    // one tick's result
    typedef struct packed {
        logic       beep_second;
        logic [6:0] lower_segments;
        logic [6:0] upper_segments;
        logic       day_indicator;
        lamp_t      ew_turn_lamp;
        lamp_t      ew_lamp;
        lamp_t      ns_turn_lamp;
        lamp_t      ns_lamp;
    } result_t;

    // a zero duration counts as one second
    function automatic logic [3:0] at_least_one(input logic [3:0] t);
        return (t == 4'd0) ? 4'd1 : t;
    endfunction

    // walk length limited to one through ten seconds
    function automatic logic [3:0] walk_len(input logic [3:0] t);
        logic [3:0] v;
        v = at_least_one(t);
        return (v > MAX_WALK) ? MAX_WALK : v;
    endfunction

endpackage

FILE: hdl/tls_core.sv
// phase sequencer state and per-tick lamp and digit logic
module tls_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step_en,
    input  logic [9:0]       light_level,
    input  logic             ns_turn_request,
    input  logic             ew_turn_request,
    input  logic             ns_walk_request,
    input  logic             ew_walk_request,
    input  tls_pkg::cfg_t    cfg,
    output tls_pkg::result_t result
);

    tls_pkg::phase_t phase_reg, phase_next, phase_cur;
    logic [3:0] seconds_left_reg, seconds_left_next, secs_cur;
    logic       day_mode_reg, day_mode_next, day_cur;
    logic [6:0] upper_pattern_reg, upper_pattern_next;
    logic [6:0] lower_pattern_reg, lower_pattern_next;

    logic       advance;
    logic       day_test;
    logic [3:0] walk_raw;
    logic [3:0] walk_digit;

    // state registers, updated once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= tls_pkg::PH_START;
            seconds_left_reg  <= 4'd0;
            day_mode_reg      <= 1'b0;
            upper_pattern_reg <= tls_pkg::BLANK_PATTERN;
            lower_pattern_reg <= tls_pkg::BLANK_PATTERN;
        end else if (step_en) begin
            phase_reg         <= phase_next;
            seconds_left_reg  <= seconds_left_next;
            day_mode_reg      <= day_mode_next;
            upper_pattern_reg <= upper_pattern_next;
            lower_pattern_reg <= lower_pattern_next;
        end
    end

    assign advance  = (seconds_left_reg == 4'd0) || (phase_reg > tls_pkg::PH_NST_YELLOW);
    assign day_test = (light_level < cfg.day_threshold);

    // phase transition when the current phase has run out
    always_comb begin
        phase_cur = phase_reg;
        secs_cur  = seconds_left_reg;
        day_cur   = day_mode_reg;
        if (advance) begin
            case (phase_reg)
                tls_pkg::PH_NS_WALK: begin
                    phase_cur = tls_pkg::PH_NS_GREEN;
                    secs_cur  = tls_pkg::at_least_one(cfg.day_ns_green_time);
                end
                tls_pkg::PH_NS_GREEN: begin
                    phase_cur = tls_pkg::PH_NS_YELLOW;
                    secs_cur  = tls_pkg::at_least_one(cfg.yellow_time);
                end
                tls_pkg::PH_NS_YELLOW, tls_pkg::PH_EWT_YELLOW: begin
                    if (phase_reg == tls_pkg::PH_NS_YELLOW && ew_turn_request) begin
                        phase_cur = tls_pkg::PH_EWT_GREEN;
                        secs_cur  = tls_pkg::at_least_one(cfg.turn_green_time);
                    end else if (day_mode_reg && ew_walk_request) begin
                        phase_cur = tls_pkg::PH_EW_WALK;
                        secs_cur  = tls_pkg::walk_len(cfg.ew_walk_time);
                    end else begin
                        phase_cur = tls_pkg::PH_EW_GREEN;
                        secs_cur  = tls_pkg::at_least_one(day_mode_reg ?
                                    cfg.day_ew_green_time : cfg.night_green_time);
                    end
                end
                tls_pkg::PH_EWT_GREEN: begin
                    phase_cur = tls_pkg::PH_EWT_YELLOW;
                    secs_cur  = tls_pkg::at_least_one(cfg.yellow_time);
                end
                tls_pkg::PH_EW_WALK: begin
                    phase_cur = tls_pkg::PH_EW_GREEN;
                    secs_cur  = tls_pkg::at_least_one(cfg.day_ew_green_time);
                end
                tls_pkg::PH_EW_GREEN: begin
                    phase_cur = tls_pkg::PH_EW_YELLOW;
                    secs_cur  = tls_pkg::at_least_one(cfg.yellow_time);
                end
                tls_pkg::PH_NST_GREEN: begin
                    phase_cur = tls_pkg::PH_NST_YELLOW;
                    secs_cur  = tls_pkg::at_least_one(cfg.yellow_time);
                end
                default: begin
                    // cycle start, also after the last yellow without a turn request
                    if (phase_reg == tls_pkg::PH_EW_YELLOW && ns_turn_request) begin
                        phase_cur = tls_pkg::PH_NST_GREEN;
                        secs_cur  = tls_pkg::at_least_one(cfg.turn_green_time);
                    end else begin
                        day_cur = day_test;
                        if (day_test && ns_walk_request) begin
                            phase_cur = tls_pkg::PH_NS_WALK;
                            secs_cur  = tls_pkg::walk_len(cfg.ns_walk_time);
                        end else begin
                            phase_cur = tls_pkg::PH_NS_GREEN;
                            secs_cur  = tls_pkg::at_least_one(day_test ?
                                        cfg.day_ns_green_time : cfg.night_green_time);
                        end
                    end
                end
            endcase
        end
    end

    // countdown digit, limited to the table
    assign walk_raw   = secs_cur - 4'd1;
    assign walk_digit = (walk_raw > tls_pkg::MAX_DIGIT) ? tls_pkg::MAX_DIGIT : walk_raw;

    // lamps, digits and beep for this second
    always_comb begin
        result.ns_lamp        = tls_pkg::LAMP_RED;
        result.ns_turn_lamp   = tls_pkg::LAMP_RED;
        result.ew_lamp        = tls_pkg::LAMP_RED;
        result.ew_turn_lamp   = tls_pkg::LAMP_RED;
        result.beep_second    = 1'b0;
        upper_pattern_next    = upper_pattern_reg;
        lower_pattern_next    = lower_pattern_reg;
        case (phase_cur)
            tls_pkg::PH_NS_WALK: begin
                upper_pattern_next = tls_pkg::SEG_TABLE[walk_digit];
                lower_pattern_next = tls_pkg::BLANK_PATTERN;
                result.ns_lamp     = tls_pkg::LAMP_GREEN;
                result.beep_second = 1'b1;
            end
            tls_pkg::PH_EW_WALK: begin
                upper_pattern_next = tls_pkg::BLANK_PATTERN;
                lower_pattern_next = tls_pkg::SEG_TABLE[walk_digit];
                result.ew_lamp     = tls_pkg::LAMP_GREEN;
                result.beep_second = 1'b1;
            end
            tls_pkg::PH_NS_GREEN:   result.ns_lamp      = tls_pkg::LAMP_GREEN;
            tls_pkg::PH_NS_YELLOW:  result.ns_lamp      = tls_pkg::LAMP_YELLOW;
            tls_pkg::PH_EWT_GREEN:  result.ew_turn_lamp = tls_pkg::LAMP_GREEN;
            tls_pkg::PH_EWT_YELLOW: result.ew_turn_lamp = tls_pkg::LAMP_YELLOW;
            tls_pkg::PH_EW_GREEN:   result.ew_lamp      = tls_pkg::LAMP_GREEN;
            tls_pkg::PH_EW_YELLOW:  result.ew_lamp      = tls_pkg::LAMP_YELLOW;
            tls_pkg::PH_NST_GREEN:  result.ns_turn_lamp = tls_pkg::LAMP_GREEN;
            default:                result.ns_turn_lamp = tls_pkg::LAMP_YELLOW;
        endcase
        result.day_indicator  = day_cur;
        result.upper_segments = upper_pattern_next;
        result.lower_segments = lower_pattern_next;
    end

    assign phase_next        = phase_cur;
    assign seconds_left_next = secs_cur - 4'd1;
    assign day_mode_next     = day_cur;

endmodule

FILE: hdl/traffic_light_sequencer.sv
// traffic light sequencer top level: stream ports, register file, result register
//
// channel   dir   signals                     width  contents
// s_        in    s_tvalid/s_tready/s_tdata   16     one second tick with sensor and requests
// m_        out   m_tvalid/m_tready/m_tdata   24     lamps, mode, digits and beep for that tick
// cfg_      in    cfg_we/cfg_index/cfg_wdata  3/10   register writes, no read-back
//
// the phase logic is combinational between the state registers and the result register,
// so one transaction is accepted in every cycle while m_tready is high.
// aresetn (synchronous, active low) clears the phase state and loads the register defaults.
// when the result register is full and m_tready is low, s_tready drops until it drains.
module traffic_light_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [9:0] light_level, [10] ns_turn_request, [11] ew_turn_request,
    // [12] ns_walk_request, [13] ew_walk_request, [15:14] zero
    input  logic [15:0]                      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [1:0] ns_lamp, [3:2] ns_turn_lamp, [5:4] ew_lamp, [7:6] ew_turn_lamp,
    // [8] day_indicator, [15:9] upper_segments, [22:16] lower_segments, [23] beep_second
    output logic [23:0]                      m_tdata,
    input  logic                             cfg_we,
    input  logic [tls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tls_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    tls_pkg::cfg_t    cfg_reg;
    tls_pkg::result_t step_result;
    logic             m_tvalid_reg;
    logic [23:0]      m_tdata_reg;
    logic             in_accept;

    // register file writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.day_threshold     <= tls_pkg::DAY_THRESHOLD_RST;
            cfg_reg.day_ns_green_time <= tls_pkg::DAY_NS_GREEN_RST;
            cfg_reg.day_ew_green_time <= tls_pkg::DAY_EW_GREEN_RST;
            cfg_reg.night_green_time  <= tls_pkg::NIGHT_GREEN_RST;
            cfg_reg.yellow_time       <= tls_pkg::YELLOW_RST;
            cfg_reg.turn_green_time   <= tls_pkg::TURN_GREEN_RST;
            cfg_reg.ns_walk_time      <= tls_pkg::NS_WALK_RST;
            cfg_reg.ew_walk_time      <= tls_pkg::EW_WALK_RST;
        end else if (cfg_we) begin
            case (tls_pkg::cfg_index_t'(cfg_index))
                tls_pkg::CFG_DAY_THRESHOLD: cfg_reg.day_threshold     <= cfg_wdata;
                tls_pkg::CFG_DAY_NS_GREEN:  cfg_reg.day_ns_green_time <= cfg_wdata[3:0];
                tls_pkg::CFG_DAY_EW_GREEN:  cfg_reg.day_ew_green_time <= cfg_wdata[3:0];
                tls_pkg::CFG_NIGHT_GREEN:   cfg_reg.night_green_time  <= cfg_wdata[3:0];
                tls_pkg::CFG_YELLOW:        cfg_reg.yellow_time       <= cfg_wdata[3:0];
                tls_pkg::CFG_TURN_GREEN:    cfg_reg.turn_green_time   <= cfg_wdata[3:0];
                tls_pkg::CFG_NS_WALK:       cfg_reg.ns_walk_time      <= cfg_wdata[3:0];
                tls_pkg::CFG_EW_WALK:       cfg_reg.ew_walk_time      <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // input transaction whenever the result register is free or draining
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    tls_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step_en         (in_accept),
        .light_level     (s_tdata[9:0]),
        .ns_turn_request (s_tdata[10]),
        .ew_turn_request (s_tdata[11]),
        .ns_walk_request (s_tdata[12]),
        .ew_walk_request (s_tdata[13]),
        .cfg             (cfg_reg),
        .result          (step_result)
    );

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_tready) begin
            m_tvalid_reg <= s_tvalid;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_tdata_reg <= step_result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
